FILE: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and helper functions of the quaternion to Euler block.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int QW             = 16;   // quaternion component width
	localparam int OW             = 16;   // angle output width
	localparam int TW             = 16;   // pole threshold width
	localparam int VW             = 36;   // width of a vector entering normalization
	localparam int AW             = 36;   // angle accumulator width, Q2.30 plus headroom
	localparam int KW             = 6;    // shift amount width
	localparam int ROOT_W         = 64;   // square root datapath width
	localparam int SQRT_STAGES    = 32;
	localparam int TAB_LEN        = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int DATA_WIDTH_DEF   = 16;

	localparam logic [TW-1:0]        THRESH_RST  = 16'd32702;
	localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
	localparam logic signed [OW-1:0] HALF_PI_Q12 = 16'sd6434;

	typedef logic [1:0] status_t;
	localparam status_t ST_NORMAL = 2'd0;
	localparam status_t ST_NORTH  = 2'd1;
	localparam status_t ST_SOUTH  = 2'd2;
	localparam status_t ST_ZERO   = 2'd3;

	// Data that rides alongside the square root chain.
	typedef struct packed {
		status_t               status;
		logic signed [VW-1:0]  hd_y;
		logic signed [VW-1:0]  hd_x;
		logic signed [VW-1:0]  at_y;
		logic signed [VW-1:0]  bk_y;
		logic signed [VW-1:0]  bk_x;
	} side_t;

	// atan(2^-i) in Q2.30, truncated.
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] r;
		unique case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// Position of the highest set bit plus one; zero for zero.
	function automatic logic [KW-1:0] bit_len(input logic [VW-1:0] v);
		logic [KW-1:0] r;
		r = '0;
		for (int k = 0; k < VW; k++) begin
			if (v[k]) r = KW'(k + 1);
		end
		return r;
	endfunction

	// Q2.30 angle to Q4.12: round half up, saturate.
	function automatic logic signed [OW-1:0] to_q12(input logic signed [AW:0] a);
		logic signed [AW+1:0] s;
		logic signed [AW+1:0] r;
		logic signed [OW-1:0] o;
		s = (AW+2)'(a) + (AW+2)'(131072);
		r = s >>> 18;
		if (r > (AW+2)'(32767))       o = 16'sh7FFF;
		else if (r < -(AW+2)'(32768)) o = 16'sh8000;
		else                          o = r[OW-1:0];
		return o;
	endfunction

endpackage

FILE: rtl/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels for quaternion beats and Euler angle beats.
// ----------------------------------------------------------------------------
interface quat_if import qte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;

	modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface euler_if import qte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] heading;
	logic signed [OW-1:0] attitude;
	logic signed [OW-1:0] bank;
	status_t              status;

	modport source(output valid, heading, attitude, bank, status, input ready);
	modport sink(input valid, heading, attitude, bank, status, output ready);
endinterface

FILE: rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of a restoring integer square root; cells chain into a pipeline.
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  logic [ROOT_W-1:0] rem_in,
	input  logic [ROOT_W-1:0] root_in,
	output logic [ROOT_W-1:0] rem_q,
	output logic [ROOT_W-1:0] root_q
);

	localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * STEP);

	logic [ROOT_W-1:0] trial;
	assign trial = root_in + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= (root_in >> 1) + BIT;
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in >> 1;
			end
		end
	end

endmodule

FILE: rtl/qte_norm.sv
// ----------------------------------------------------------------------------
// qte_norm
// Fold a vector into the right half plane and scale it by powers of two
// so its largest component sits just below the CORDIC range limit.
// ----------------------------------------------------------------------------
module qte_norm import qte_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VW-1:0]    vx,
	input  logic signed [VW-1:0]    vy,
	output logic signed [DATA_WIDTH:0] ox,
	output logic signed [DATA_WIDTH:0] oy,
	output logic signed [AW-1:0]    oz,
	output logic                    ozero
);

	localparam int            CW = DATA_WIDTH + 1;
	localparam logic [KW-1:0] HB = KW'(DATA_WIDTH - 2);

	logic signed [VW-1:0] x_s1, y_s1, x_s2, y_s2;
	logic signed [AW-1:0] z_s1, z_s2;
	logic                 zero_s1, zero_s2;
	logic [KW-1:0]        kr_s2, kl_s2;

	// fold
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (vx == '0) && (vy == '0);
			if (vx[VW-1]) begin
				x_s1 <= -vx;
				y_s1 <= -vy;
				z_s1 <= vy[VW-1] ? -ANG_PI : ANG_PI;
			end else begin
				x_s1 <= vx;
				y_s1 <= vy;
				z_s1 <= '0;
			end
		end
	end

	// shift amounts; a negative y loses magnitude more slowly under floor shifts
	logic [VW-1:0] u, my, m, ush;
	logic [KW-1:0] lx, lu, lm, kx, ky0, ky, kr, kl;

	always_comb begin
		lx  = bit_len(x_s1);
		kx  = (lx > HB) ? lx - HB : '0;
		u   = y_s1[VW-1] ? ~y_s1 : y_s1;
		lu  = bit_len(u);
		ky0 = (lu > HB) ? lu - HB : '0;
		ush = u >> ky0;
		ky  = (y_s1[VW-1] && (&ush[DATA_WIDTH-3:0])) ? ky0 + KW'(1) : ky0;
		kr  = (kx > ky) ? kx : ky;
		my  = y_s1[VW-1] ? -y_s1 : y_s1;
		m   = (x_s1 > $signed(my)) ? x_s1 : my;
		lm  = bit_len(m);
		kl  = (lm < HB) ? HB - lm : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			zero_s2 <= zero_s1;
			kr_s2   <= kr;
			kl_s2   <= kl;
		end
	end

	// apply the shift
	logic signed [VW-1:0] xs, ys;
	assign xs = (x_s2 >>> kr_s2) <<< kl_s2;
	assign ys = (y_s2 >>> kr_s2) <<< kl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ox    <= xs[CW-1:0];
			oy    <= ys[CW-1:0];
			oz    <= z_s2;
			ozero <= zero_s2;
		end
	end

endmodule

FILE: rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring micro-rotation; cells chain into the CORDIC pipeline.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int STEP       = 0
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [DATA_WIDTH:0] x_in,
	input  logic signed [DATA_WIDTH:0] y_in,
	input  logic signed [AW-1:0]       z_in,
	input  logic                       zero_in,
	output logic signed [DATA_WIDTH:0] x_q,
	output logic signed [DATA_WIDTH:0] y_q,
	output logic signed [AW-1:0]       z_q,
	output logic                       zero_q
);

	localparam logic signed [AW-1:0] ATAN = AW'(atan_q30(STEP));

	logic signed [DATA_WIDTH:0] dx, dy;
	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_in;
			if (!y_in[DATA_WIDTH]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end
		end
	end

endmodule

FILE: rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler: heading, attitude and bank from a Q2.14 quaternion
// Pipeline: 3 product/test stages, 32 square root cells, 3 normalize stages,
//   the CORDIC cells and the output register.
// Throughput: one beat per cycle; a waiting result stalls only with a beat at the tail.
// Reset: arst_n clears all valid flags and loads thr_q with 0.499 (32702).
// ----------------------------------------------------------------------------
module quaternion_to_euler import qte_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [TW-1:0] cfg_wdata,
	quat_if.sink          quat_in,
	euler_if.source       euler_out
);

	localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
	localparam int CW    = DATA_WIDTH + 1;
	localparam int HEAD  = 3;                       // product and pole test stages
	localparam int TAIL  = 3 + STEPS;               // normalize plus CORDIC
	localparam int TOT   = HEAD + SQRT_STAGES + TAIL;

	// ------------------------------------------------------------------
	// Flow control: the whole pipe advances together. It holds only when
	// the output register is full, not taken, and a real beat is behind it.
	// A bubble at the tail is simply dropped so input keeps flowing.
	// ------------------------------------------------------------------
	logic           en;
	logic [TOT-1:0] vld_q;
	logic           out_v_q;

	assign en            = euler_out.ready || !out_v_q || !vld_q[TOT-1];
	assign quat_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], quat_in.valid};
		end
	end

	// Threshold register; write only while idle (not enforced by the block).
	logic [TW-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: all pairwise products and the sums/differences that feed
	// the two squared lengths under the attitude square root.
	// ------------------------------------------------------------------
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, xw_s1, yz_s1;
	logic signed [16:0] xmy_s1, zmw_s1, xpy_s1, zpw_s1;
	logic signed [QW-1:0] qx_s1, qw_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1  <= quat_in.quat_w * quat_in.quat_w;
			xx_s1  <= quat_in.quat_x * quat_in.quat_x;
			yy_s1  <= quat_in.quat_y * quat_in.quat_y;
			zz_s1  <= quat_in.quat_z * quat_in.quat_z;
			xy_s1  <= quat_in.quat_x * quat_in.quat_y;
			zw_s1  <= quat_in.quat_z * quat_in.quat_w;
			yw_s1  <= quat_in.quat_y * quat_in.quat_w;
			xz_s1  <= quat_in.quat_x * quat_in.quat_z;
			xw_s1  <= quat_in.quat_x * quat_in.quat_w;
			yz_s1  <= quat_in.quat_y * quat_in.quat_z;
			xmy_s1 <= 17'(quat_in.quat_x) - 17'(quat_in.quat_y);
			zmw_s1 <= 17'(quat_in.quat_z) - 17'(quat_in.quat_w);
			xpy_s1 <= 17'(quat_in.quat_x) + 17'(quat_in.quat_y);
			zpw_s1 <= 17'(quat_in.quat_z) + 17'(quat_in.quat_w);
			qx_s1  <= quat_in.quat_x;
			qw_s1  <= quat_in.quat_w;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: norm, pole term, atan2 operands, squared lengths a and b.
	// ------------------------------------------------------------------
	logic signed [33:0] sq_xmy, sq_zmw, sq_xpy, sq_zpw;
	assign sq_xmy = xmy_s1 * xmy_s1;
	assign sq_zmw = zmw_s1 * zmw_s1;
	assign sq_xpy = xpy_s1 * xpy_s1;
	assign sq_zpw = zpw_s1 * zpw_s1;

	logic signed [34:0]   n_s2;
	logic signed [33:0]   t_s2;
	logic signed [VW-1:0] hy_s2, hx_s2, by_s2, bx_s2;
	logic [33:0]          a_s2, b_s2;
	logic signed [QW-1:0] qx_s2, qw_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2  <= 35'(ww_s1) + 35'(xx_s1) + 35'(yy_s1) + 35'(zz_s1);
			t_s2  <= 34'(xy_s1) + 34'(zw_s1);
			hy_s2 <= (VW'(yw_s1) - VW'(xz_s1)) <<< 1;
			hx_s2 <= VW'(xx_s1) - VW'(yy_s1) - VW'(zz_s1) + VW'(ww_s1);
			by_s2 <= (VW'(xw_s1) - VW'(yz_s1)) <<< 1;
			bx_s2 <= VW'(yy_s1) - VW'(xx_s1) - VW'(zz_s1) + VW'(ww_s1);
			a_s2  <= sq_xmy + sq_zmw;
			b_s2  <= sq_xpy + sq_zpw;
			qx_s2 <= qx_s1;
			qw_s2 <= qw_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: threshold times norm, shifted pole term, and the product
	// whose square root gives cos(attitude) scaled by the norm.
	// ------------------------------------------------------------------
	logic [49:0]          lim_s3;
	logic signed [49:0]   tt_s3;
	logic [ROOT_W-1:0]    prod_s3;
	logic                 nz_s3;
	logic signed [VW-1:0] hy_s3, hx_s3, ty_s3, by_s3, bx_s3;
	logic signed [QW-1:0] qx_s3, qw_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			lim_s3  <= thr_q * n_s2[33:0];
			tt_s3   <= 50'(t_s2) <<< 16;
			prod_s3 <= ROOT_W'(a_s2[33:2]) * ROOT_W'(b_s2[33:2]);
			nz_s3   <= (n_s2 == '0);
			hy_s3   <= hy_s2;
			hx_s3   <= hx_s2;
			ty_s3   <= VW'(t_s2) <<< 1;
			by_s3   <= by_s2;
			bx_s3   <= bx_s2;
			qx_s3   <= qx_s2;
			qw_s3   <= qw_s2;
		end
	end

	// Pole test; at a pole the heading lane runs atan2(x, w) instead.
	logic signed [50:0] lim_sg, tt_sg;
	logic               north, south;
	side_t              side_in;

	assign lim_sg = {1'b0, lim_s3};
	assign tt_sg  = 51'(tt_s3);
	assign north  = tt_sg > lim_sg;
	assign south  = tt_sg < -lim_sg;

	always_comb begin
		side_in.at_y = ty_s3;
		side_in.bk_y = by_s3;
		side_in.bk_x = bx_s3;
		side_in.hd_y = hy_s3;
		side_in.hd_x = hx_s3;
		priority if (nz_s3) begin
			side_in.status = ST_ZERO;
		end else if (north || south) begin
			side_in.status = north ? ST_NORTH : ST_SOUTH;
			side_in.hd_y   = VW'(qx_s3);
			side_in.hd_x   = VW'(qw_s3);
		end else begin
			side_in.status = ST_NORMAL;
		end
	end

	// ------------------------------------------------------------------
	// Square root chain, one result bit per cell; side data rides along.
	// ------------------------------------------------------------------
	logic [ROOT_W-1:0] rem_w  [0:SQRT_STAGES];
	logic [ROOT_W-1:0] root_w [0:SQRT_STAGES];
	side_t             sd_q   [0:SQRT_STAGES-1];

	assign rem_w[0]  = prod_s3;
	assign root_w[0] = '0;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
		qte_sqrt_cell #(.STEP(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_in (rem_w[i]),
			.root_in(root_w[i]),
			.rem_q  (rem_w[i+1]),
			.root_q (root_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= side_in;
			for (int i = 1; i < SQRT_STAGES; i++) sd_q[i] <= sd_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Three lanes: heading, attitude, bank. Each folds, normalizes and
	// runs the CORDIC cell chain. Attitude uses x = 4 * sqrt.
	// ------------------------------------------------------------------
	side_t                sd_tail;
	logic signed [VW-1:0] lane_x [0:2];
	logic signed [VW-1:0] lane_y [0:2];

	assign sd_tail   = sd_q[SQRT_STAGES-1];
	assign lane_x[0] = sd_tail.hd_x;
	assign lane_y[0] = sd_tail.hd_y;
	assign lane_x[1] = {2'b00, root_w[SQRT_STAGES][31:0], 2'b00};
	assign lane_y[1] = sd_tail.at_y;
	assign lane_x[2] = sd_tail.bk_x;
	assign lane_y[2] = sd_tail.bk_y;

	logic signed [CW-1:0] cx_w [0:2][0:STEPS];
	logic signed [CW-1:0] cy_w [0:2][0:STEPS];
	logic signed [AW-1:0] cz_w [0:2][0:STEPS];
	logic                 c0_w [0:2][0:STEPS];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		qte_norm #(.DATA_WIDTH(DATA_WIDTH)) u_norm (
			.clk  (clk),
			.en   (en),
			.vx   (lane_x[l]),
			.vy   (lane_y[l]),
			.ox   (cx_w[l][0]),
			.oy   (cy_w[l][0]),
			.oz   (cz_w[l][0]),
			.ozero(c0_w[l][0])
		);
		for (genvar s = 0; s < STEPS; s++) begin : g_step
			qte_cordic_cell #(.DATA_WIDTH(DATA_WIDTH), .STEP(s)) u_cell (
				.clk    (clk),
				.en     (en),
				.x_in   (cx_w[l][s]),
				.y_in   (cy_w[l][s]),
				.z_in   (cz_w[l][s]),
				.zero_in(c0_w[l][s]),
				.x_q    (cx_w[l][s+1]),
				.y_q    (cy_w[l][s+1]),
				.z_q    (cz_w[l][s+1]),
				.zero_q (c0_w[l][s+1])
			);
		end
	end

	// Status rides next to the lanes.
	status_t st_q [0:TAIL-1];
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= sd_tail.status;
			for (int i = 1; i < TAIL; i++) st_q[i] <= st_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Final selection and rounding into the output register.
	// ------------------------------------------------------------------
	status_t              st_end;
	logic signed [AW-1:0] za [0:2];
	logic signed [AW:0]   hz;
	logic signed [OW-1:0] hd_o, at_o, bk_o;

	assign st_end = st_q[TAIL-1];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			za[l] = c0_w[l][STEPS] ? '0 : cz_w[l][STEPS];
		end
		hz   = (AW+1)'(za[0]);
		hd_o = '0;
		at_o = '0;
		bk_o = '0;
		unique case (st_end)
			ST_NORMAL: begin
				hd_o = to_q12(hz);
				at_o = to_q12((AW+1)'(za[1]));
				bk_o = to_q12((AW+1)'(za[2]));
			end
			ST_NORTH: begin
				hd_o = to_q12(hz <<< 1);
				at_o = HALF_PI_Q12;
			end
			ST_SOUTH: begin
				hd_o = to_q12(-(hz <<< 1));
				at_o = -HALF_PI_Q12;
			end
			ST_ZERO: begin
				hd_o = '0;
			end
			default: begin
				hd_o = '0;
			end
		endcase
	end

	logic signed [OW-1:0] hd_q, at_q, bk_q;
	status_t              st_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (euler_out.ready || !out_v_q) begin
			out_v_q <= vld_q[TOT-1];
		end
	end

	// Load payload whenever the register may change.
	always_ff @(posedge clk) begin
		if (euler_out.ready || !out_v_q) begin
			hd_q   <= hd_o;
			at_q   <= at_o;
			bk_q   <= bk_o;
			st_o_q <= st_end;
		end
	end

	assign euler_out.valid    = out_v_q;
	assign euler_out.heading  = hd_q;
	assign euler_out.attitude = at_q;
	assign euler_out.bank     = bk_q;
	assign euler_out.status   = st_o_q;

`ifndef SYNTHESIS
	// A zero quaternion reports all angles zero.
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		euler_out.valid && euler_out.status == ST_ZERO |->
		euler_out.heading == '0 && euler_out.attitude == '0 && euler_out.bank == '0)
		else $error("zero quaternion with nonzero angles");

	// Pole results carry a fixed attitude and zero bank.
	a_pole_out: assert property (@(posedge clk) disable iff (!arst_n)
		euler_out.valid && (euler_out.status == ST_NORTH || euler_out.status == ST_SOUTH) |->
		euler_out.bank == '0 &&
		(euler_out.attitude == HALF_PI_Q12 || euler_out.attitude == -HALF_PI_Q12))
		else $error("pole beat with wrong attitude or bank");

	// Input backpressure only comes from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!quat_in.ready |-> euler_out.valid && !euler_out.ready)
		else $error("input stalled without a held result");
`endif

endmodule

FILE: dv/tb_quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// Streams quaternion beats through the converter with random gaps and output
// stalls, predicts every Euler beat in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;
	timeunit 1ns;
	timeprecision 1ps;

	import qte_pkg::*;

	localparam int STEPS   = 16;
	localparam int DWIDTH  = 16;
	localparam int LATENCY = 39 + STEPS;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [OW-1:0] heading;
		logic signed [OW-1:0] attitude;
		logic signed [OW-1:0] bank;
		status_t              status;
	} euler_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TW-1:0] cfg_wdata;

	quat_if  quat_in();
	euler_if euler_out();

	quaternion_to_euler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.quat_in  (quat_in.sink),
		.euler_out(euler_out.source)
	);

	// Table of atan(2^-i) in Q2.30, truncated.
	localparam longint ATAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
	localparam longint PI_Q30 = 64'd3373259426;

	logic [TW-1:0] pole_thresh;   // mirror of the block's register
	quat_t  pending_quats[$];
	euler_t expected_angles[$];
	int     n_fail;
	int     n_checked;
	int     n_pole;
	int     n_zero;

	// Shift right rounding toward minus infinity; >>> on longint already floors.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint iroot(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC atan2(y, x), Q2.30.
	function automatic longint vec_atan2(longint y, longint x);
		longint ang, m, hi, lo, dx, dy;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			ang = (y >= 0) ? PI_Q30 : -PI_Q30;
			x = -x;
			y = -y;
		end
		hi = 64'sd1 << (DWIDTH - 2);
		lo = 64'sd1 << (DWIDTH - 3);
		m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
		while (m >= hi) begin
			x = floor_shr(x, 1);
			y = floor_shr(y, 1);
			m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
		end
		while (m < lo) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				ang += ATAN_Q30[i];
			end else begin
				x -= dx;
				y += dy;
				ang -= ATAN_Q30[i];
			end
		end
		return ang;
	endfunction

	function automatic logic signed [OW-1:0] angle_q12(longint a);
		longint r;
		r = floor_shr(a + (64'sd1 << 17), 18);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return OW'(r);
	endfunction

	function automatic euler_t predict_euler(quat_t q);
		euler_t e;
		longint w, x, y, z, sw, sx, sy, sz, n, t, lim, a, b, c;
		w = q.w; x = q.x; y = q.y; z = q.z;
		sw = w * w; sx = x * x; sy = y * y; sz = z * z;
		n = sw + sx + sy + sz;
		t = x * y + z * w;
		lim = longint'(pole_thresh) * n;
		e = '0;
		if (n == 0) begin
			e.status = ST_ZERO;
		end else if (t * 65536 > lim) begin
			e.status   = ST_NORTH;
			e.heading  = angle_q12(2 * vec_atan2(x, w));
			e.attitude = HALF_PI_Q12;
		end else if (t * 65536 < -lim) begin
			e.status   = ST_SOUTH;
			e.heading  = angle_q12(-2 * vec_atan2(x, w));
			e.attitude = -HALF_PI_Q12;
		end else begin
			a = (x - y) * (x - y) + (z - w) * (z - w);
			b = (x + y) * (x + y) + (z + w) * (z + w);
			c = iroot((longint'(unsigned'(a)) >> 2) * (longint'(unsigned'(b)) >> 2));
			e.status   = ST_NORMAL;
			e.heading  = angle_q12(vec_atan2(2 * (y * w - x * z), sx - sy - sz + sw));
			e.attitude = angle_q12(vec_atan2(2 * t, 4 * c));
			e.bank     = angle_q12(vec_atan2(2 * (x * w - y * z), -sx + sy - sz + sw));
		end
		return e;
	endfunction

	// Clock: 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Driver: present the head of the queue after its gap; hold until taken.
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_in.valid  <= 1'b0;
			quat_in.quat_w <= '0;
			quat_in.quat_x <= '0;
			quat_in.quat_y <= '0;
			quat_in.quat_z <= '0;
			src_gap        <= $urandom_range(0, 15);
		end else begin
			if (quat_in.valid && quat_in.ready) begin
				// beat accepted: predict it and drop it from the queue
				expected_angles.push_back(predict_euler({quat_in.quat_w, quat_in.quat_x,
					quat_in.quat_y, quat_in.quat_z}));
				void'(pending_quats.pop_front());
			end
			if (quat_in.valid && !quat_in.ready) begin
				// hold the beat until taken
			end else if (src_gap != 0) begin
				src_gap       <= src_gap - 1;
				quat_in.valid <= 1'b0;
			end else if (pending_quats.size() != 0) begin
				quat_in.valid  <= 1'b1;
				quat_in.quat_w <= pending_quats[0].w;
				quat_in.quat_x <= pending_quats[0].x;
				quat_in.quat_y <= pending_quats[0].y;
				quat_in.quat_z <= pending_quats[0].z;
				// gap after this beat; zero often, for back-to-back runs
				src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			end else begin
				quat_in.valid <= 1'b0;
			end
		end
	end

	// Monitor: random stall on ready, check every accepted Euler beat.
	int sink_stall;
	euler_t got;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler_out.ready <= 1'b0;
			sink_stall      <= $urandom_range(0, 15);
		end else begin
			if (euler_out.valid && euler_out.ready) begin
				got = {euler_out.heading, euler_out.attitude, euler_out.bank, euler_out.status};
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %p", $time, got);
					n_fail++;
				end else begin
					if (got.status == ST_ZERO) n_zero++;
					if (got.status == ST_NORTH || got.status == ST_SOUTH) n_pole++;
					if (got.heading !== expected_angles[0].heading)
						$display("%0t: heading expected %0d actual %0d", $time,
							expected_angles[0].heading, got.heading);
					if (got.attitude !== expected_angles[0].attitude)
						$display("%0t: attitude expected %0d actual %0d", $time,
							expected_angles[0].attitude, got.attitude);
					if (got.bank !== expected_angles[0].bank)
						$display("%0t: bank expected %0d actual %0d", $time,
							expected_angles[0].bank, got.bank);
					if (got.status !== expected_angles[0].status)
						$display("%0t: status expected %0d actual %0d", $time,
							expected_angles[0].status, got.status);
					if (got !== expected_angles[0]) n_fail++;
					void'(expected_angles.pop_front());
					n_checked++;
				end
			end
			// stretches with no stall, otherwise a random stall per beat
			if (sink_stall != 0) begin
				sink_stall      <= sink_stall - 1;
				euler_out.ready <= 1'b0;
			end else begin
				euler_out.ready <= 1'b1;
				if (euler_out.valid && euler_out.ready)
					sink_stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
			end
		end
	end

	function automatic quat_t rand_quat();
		quat_t q;
		q.w = QW'($urandom); q.x = QW'($urandom); q.y = QW'($urandom); q.z = QW'($urandom);
		// mostly unit-ish quaternions, with scaled-down and raw noise mixed in
		case ($urandom_range(0, 5))
			0: q = q;
			1: begin
				q.w = q.w >>> $urandom_range(0, 14); q.x = q.x >>> $urandom_range(0, 14);
				q.y = q.y >>> $urandom_range(0, 14); q.z = q.z >>> $urandom_range(0, 14);
			end
			2: begin
				// near a pole unless exactly one sign flips: x*y + z*w close to +-n/2
				q.y = QW'(q.x + $signed(QW'($urandom_range(0, 200))) - 100);
				q.z = QW'(q.w + $signed(QW'($urandom_range(0, 200))) - 100);
				if ($urandom_range(0, 1)) q.y = -q.y;
				if ($urandom_range(0, 1)) q.z = -q.z;
			end
			default: begin
				q.w = q.w >>> 2; q.x = q.x >>> 2; q.y = q.y >>> 2; q.z = q.z >>> 2;
			end
		endcase
		return q;
	endfunction

	task automatic wait_idle();
		while (pending_quats.size() != 0 || expected_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_thresh(logic [TW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pole_thresh = v;
	endtask

	localparam logic [TW-1:0] THRESH_SET [5] = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd32702};

	initial begin
		quat_t q;
		n_fail = 0; n_checked = 0; n_pole = 0; n_zero = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pole_thresh = THRESH_RST;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero, both poles, negative x in atan2
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_quats.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
		pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
		pending_quats.push_back('{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
		pending_quats.push_back('{-16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192});
		pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd1});
		pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
		// send nothing more until every result is back
		wait_idle();

		// phases over several thresholds, extremes among them
		foreach (THRESH_SET[k]) begin
			write_thresh(THRESH_SET[k]);
			for (int i = 0; i < 330; i++) begin
				q = rand_quat();
				pending_quats.push_back(q);
			end
			wait_idle();
		end

		$display("Checked %0d Euler beats over %0d thresholds (%0d pole, %0d zero).",
			n_checked, $size(THRESH_SET), n_pole, n_zero);
		if (n_fail == 0) begin
			$display("tb_quaternion_to_euler: PASS");
		end else begin
			$display("tb_quaternion_to_euler: FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_quaternion_to_euler: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_sqrt_cell.sv
rtl/qte_norm.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler.sv
dv/tb_quaternion_to_euler.sv
